>>> src/gnps_pkg.sv
// shared constants for the grid nearest point search block
package gnps_pkg;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_RSVD   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [2:0] REG_ORG_X = 3'd0;
  localparam logic [2:0] REG_ORG_Y = 3'd1;
  localparam logic [2:0] REG_ORG_Z = 3'd2;
  localparam logic [2:0] REG_SHIFT = 3'd3;
  localparam logic [2:0] REG_NX    = 3'd4;
  localparam logic [2:0] REG_NY    = 3'd5;
  localparam logic [2:0] REG_NZ    = 3'd6;

  localparam int DIST_W = 50;

endpackage

>>> src/gnps_ram.sv
// generic single-port-write, single-read ram with registered read
module gnps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/gnps_axis_cell.sv
// clamped cell index along one axis
module gnps_axis_cell #(
  parameter int CW = 24,
  parameter int AW = 4
) (
  input  logic signed [CW-1:0] coord,
  input  logic signed [CW-1:0] origin,
  input  logic [4:0]           shift,
  input  logic [AW:0]          ncells,
  output logic [AW-1:0]        cell_idx
);
  logic signed [CW:0] d;
  logic [CW-1:0]      q;
  always_comb begin
    d = CW'(0) + {coord[CW-1], coord} - {origin[CW-1], origin};
    q = d[CW-1:0] >> shift;
    if (d[CW]) begin
      cell_idx = '0;
    end else if ({{(CW-AW-1){1'b0}}, ncells} <= q) begin
      cell_idx = AW'(ncells - 1'b1);
    end else begin
      cell_idx = q[AW-1:0];
    end
  end
endmodule

>>> src/grid_nearest_point_search.sv
// top level of the grid nearest point search block
//  channel | dir | tdata fields (low bit up)               | tuser
//  in_     | in  | coord_x, coord_y, coord_z (72 bits)     | kind
//  out_    | out | dist_sq (50 bits, zero padded to 56)    | status
//  cfg_    | in  | plain write: we, index, 24-bit data     | -
// clear sweeps every cell counter, one per cycle
// insert does a counter read, then the store and counter writes
// query scans every in-grid cell and each stored point, one point a cycle
// through a shared squared-distance unit
// after reset a clearing pass over every cell counter runs with in_tready low
// the result waits in an output register; the next item is taken once it leaves
module grid_nearest_point_search #(
  parameter int MAX_CELLS_PER_AXIS = 16,
  parameter int BUCKET_DEPTH       = 32,
  parameter int COORD_BITS         = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [(3*COORD_BITS+7)/8*8-1:0] in_tdata, // coord_x, coord_y, coord_z
  input  logic [1:0]  in_tuser,                    // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,                   // dist_sq
  output logic [1:0]  out_tuser,                   // status
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import gnps_pkg::*;

  localparam int AW  = $clog2(MAX_CELLS_PER_AXIS) > 0 ? $clog2(MAX_CELLS_PER_AXIS) : 1;
  localparam int CIW = 3 * AW;
  localparam int NCELL = 1 << CIW;
  localparam int BW  = $clog2(BUCKET_DEPTH) > 0 ? $clog2(BUCKET_DEPTH) : 1;
  localparam int CNTW = $clog2(BUCKET_DEPTH + 1);
  localparam int PW  = 3 * COORD_BITS;
  localparam int DW  = COORD_BITS + 1;
  localparam int SQW = 2 * DW;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_INS1  = 4'd3;
  localparam logic [3:0] S_INS2  = 4'd4;
  localparam logic [3:0] S_QCELL = 4'd5;
  localparam logic [3:0] S_QCNT  = 4'd6;
  localparam logic [3:0] S_QPT   = 4'd7;
  localparam logic [3:0] S_QLAST = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_r, state_nxt;

  // configuration
  logic signed [23:0] org_x_r, org_y_r, org_z_r;
  logic [4:0] shift_r, nx_cfg_r, ny_cfg_r, nz_cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0; org_y_r <= '0; org_z_r <= '0;
      shift_r <= 5'd10; nx_cfg_r <= 5'd16; ny_cfg_r <= 5'd16; nz_cfg_r <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORG_X: org_x_r  <= cfg_data;
        REG_ORG_Y: org_y_r  <= cfg_data;
        REG_ORG_Z: org_z_r  <= cfg_data;
        REG_SHIFT: shift_r  <= cfg_data[4:0];
        REG_NX:    nx_cfg_r <= cfg_data[4:0];
        REG_NY:    ny_cfg_r <= cfg_data[4:0];
        REG_NZ:    nz_cfg_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // effective cell counts: zero acts as one, clamp to the max
  function automatic logic [AW:0] eff(input logic [4:0] n);
    if (n == 5'd0) return (AW+1)'(1);
    if (32'(n) > MAX_CELLS_PER_AXIS) return (AW+1)'(MAX_CELLS_PER_AXIS);
    return (AW+1)'(n);
  endfunction
  logic [AW:0] nx, ny, nz;
  assign nx = eff(nx_cfg_r);
  assign ny = eff(ny_cfg_r);
  assign nz = eff(nz_cfg_r);

  // captured item
  logic [1:0] kind_r;
  logic signed [COORD_BITS-1:0] px_r, py_r, pz_r;
  logic [AW-1:0] cx, cy, cz;
  logic signed [COORD_BITS-1:0] org_x_c, org_y_c, org_z_c;
  assign org_x_c = COORD_BITS'(org_x_r);
  assign org_y_c = COORD_BITS'(org_y_r);
  assign org_z_c = COORD_BITS'(org_z_r);

  gnps_axis_cell #(.CW(COORD_BITS), .AW(AW)) u_cx (
    .coord(px_r), .origin(org_x_c), .shift(shift_r), .ncells(nx), .cell_idx(cx));
  gnps_axis_cell #(.CW(COORD_BITS), .AW(AW)) u_cy (
    .coord(py_r), .origin(org_y_c), .shift(shift_r), .ncells(ny), .cell_idx(cy));
  gnps_axis_cell #(.CW(COORD_BITS), .AW(AW)) u_cz (
    .coord(pz_r), .origin(org_z_c), .shift(shift_r), .ncells(nz), .cell_idx(cz));

  // cell counter memory and point store
  logic            cnt_we;
  logic [CIW-1:0]  cnt_waddr, cnt_raddr;
  logic [CNTW-1:0] cnt_wdata, cnt_rdata;
  gnps_ram #(.WIDTH(CNTW), .DEPTH(NCELL)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata));

  logic              pt_we;
  logic [CIW+BW-1:0] pt_waddr, pt_raddr;
  logic [PW-1:0]     pt_rdata;
  gnps_ram #(.WIDTH(PW), .DEPTH(NCELL * (1 << BW))) u_pts (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata({pz_r, py_r, px_r}),
    .raddr(pt_raddr), .rdata(pt_rdata));

  // scan counters
  logic [CIW-1:0]  sweep_r, sweep_nxt;   // clear sweep address
  logic [AW-1:0]   ix_r, iy_r, iz_r, ix_nxt, iy_nxt, iz_nxt;
  logic [CIW-1:0]  ci_r, ci_nxt;         // cell being read out
  logic [CNTW-1:0] n_r, n_nxt, k_r, k_nxt;
  logic            cells_done_r, cells_done_nxt;
  logic            pvld_r, pvld_nxt;     // point data valid next cycle
  logic            found_r, found_nxt;
  logic [SQW+1:0]  best_r, best_nxt;
  logic [1:0]      st_r, st_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;

  // shared distance unit: one stored point per cycle
  logic signed [COORD_BITS-1:0] sx, sy, sz;
  logic signed [DW-1:0] dx, dy, dz;
  logic [SQW+1:0] dsum;
  assign {sz, sy, sx} = pt_rdata;
  assign dx = DW'(px_r) - DW'(sx);
  assign dy = DW'(py_r) - DW'(sy);
  assign dz = DW'(pz_r) - DW'(sz);
  logic [SQW-1:0] qx_r, qy_r, qz_r;
  logic           qv_r;
  always_ff @(posedge clk) begin
    qx_r <= SQW'(dx * dx);
    qy_r <= SQW'(dy * dy);
    qz_r <= SQW'(dz * dz);
  end
  assign dsum = (SQW+2)'(qx_r) + (SQW+2)'(qy_r) + (SQW+2)'(qz_r);

  logic last_cell;
  assign last_cell = (32'(ix_r) == 32'(nx) - 1) && (32'(iy_r) == 32'(ny) - 1)
                   && (32'(iz_r) == 32'(nz) - 1);

  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    ix_nxt = ix_r; iy_nxt = iy_r; iz_nxt = iz_r;
    ci_nxt = ci_r; n_nxt = n_r; k_nxt = k_r;
    cells_done_nxt = cells_done_r;
    pvld_nxt = 1'b0;
    found_nxt = found_r; best_nxt = best_r;
    st_nxt = st_r; dist_nxt = dist_r;
    cnt_we = 1'b0; cnt_waddr = sweep_r; cnt_wdata = '0;
    cnt_raddr = {iz_r, iy_r, ix_r};
    pt_we = 1'b0; pt_waddr = {cz, cy, cx, k_r[BW-1:0]};
    pt_raddr = {ci_r, k_r[BW-1:0]};
    in_tready = 1'b0;

    // fold the registered squared distance of a stored point into the minimum
    if (qv_r) begin
      if (!found_r || dsum < best_r) begin
        best_nxt = dsum;
      end
      found_nxt = 1'b1;
    end

    unique case (state_r)
      S_INIT, S_CLR: begin
        cnt_we = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (&sweep_r) begin
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_OUT;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        st_nxt = ST_OK; dist_nxt = '0;
        found_nxt = 1'b0; sweep_nxt = '0;
        cells_done_nxt = 1'b0;
        ix_nxt = '0; iy_nxt = '0; iz_nxt = '0;
        if (in_tvalid) begin
          unique case (in_tuser)
            KIND_CLEAR:  state_nxt = S_CLR;
            KIND_INSERT: state_nxt = S_INS1;
            KIND_QUERY:  state_nxt = S_QCELL;
            default:     state_nxt = S_OUT;
          endcase
        end
      end
      S_INS1: begin
        cnt_raddr = {cz, cy, cx};
        state_nxt = S_INS2;
        k_nxt = '0;
        cells_done_nxt = 1'b0;
        if (cells_done_r) begin
          k_nxt = cnt_rdata;
        end
        cells_done_nxt = ~cells_done_r;
        if (cells_done_r) begin
          state_nxt = S_INS2;
        end else begin
          state_nxt = S_INS1;
        end
      end
      S_INS2: begin
        if (32'(k_r) >= BUCKET_DEPTH) begin
          st_nxt = ST_FULL;
        end else begin
          pt_we = 1'b1;
          cnt_we = 1'b1;
          cnt_waddr = {cz, cy, cx};
          cnt_wdata = k_r + 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_QCELL: begin
        // counter for cell (ix,iy,iz) is read this cycle
        ci_nxt = {iz_r, iy_r, ix_r};
        cells_done_nxt = last_cell;
        if (32'(ix_r) == 32'(nx) - 1) begin
          ix_nxt = '0;
          if (32'(iy_r) == 32'(ny) - 1) begin
            iy_nxt = '0;
            iz_nxt = iz_r + 1'b1;
          end else begin
            iy_nxt = iy_r + 1'b1;
          end
        end else begin
          ix_nxt = ix_r + 1'b1;
        end
        state_nxt = S_QCNT;
      end
      S_QCNT: begin
        n_nxt = cnt_rdata;
        k_nxt = '0;
        if (cnt_rdata == '0) begin
          state_nxt = cells_done_r ? S_QLAST : S_QCELL;
        end else begin
          state_nxt = S_QPT;
        end
      end
      S_QPT: begin
        // issue reads for points of this cell, one per cycle
        pvld_nxt = 1'b1;
        k_nxt = k_r + 1'b1;
        if (k_r + 1'b1 == n_r) begin
          state_nxt = cells_done_r ? S_QLAST : S_QCELL;
        end
      end
      S_QLAST: begin
        // wait until the distance pipe drains
        if (!pvld_r && !qv_r) begin
          if (found_r) begin
            dist_nxt = DIST_W'(best_r);
          end else begin
            st_nxt = ST_EMPTY;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      sweep_r <= '0;
      pvld_r <= 1'b0;
      qv_r <= 1'b0;
      cells_done_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      pvld_r <= pvld_nxt;
      qv_r <= pvld_r;
      cells_done_r <= cells_done_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ix_r <= ix_nxt; iy_r <= iy_nxt; iz_r <= iz_nxt;
    ci_r <= ci_nxt; n_r <= n_nxt; k_r <= k_nxt;
    best_r <= best_nxt; st_r <= st_nxt; dist_r <= dist_nxt;
    if (in_tready && in_tvalid) begin
      kind_r <= in_tuser;
      px_r <= in_tdata[COORD_BITS-1:0];
      py_r <= in_tdata[2*COORD_BITS-1:COORD_BITS];
      pz_r <= in_tdata[3*COORD_BITS-1:2*COORD_BITS];
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = st_r;
  assign out_tdata  = 56'(dist_r);

`ifndef SYNTH
  // a full bucket is only ever reported for an insert
  a_full_ins: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> kind_r == KIND_INSERT)
    else $error("full status on a non-insert");
  // the point store is never written outside an insert
  a_wr_ins: assert property (@(posedge clk) disable iff (!rst_n)
    pt_we |-> state_r == S_INS2)
    else $error("point store written outside insert");
  // nonzero distance only for queries
  a_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && kind_r != KIND_QUERY |-> dist_r == '0)
    else $error("distance on a non-query");
`endif
endmodule
